/* sv/csds_pkg.sv */
// ----------------------------------------------------------------------------
// csds_pkg: shared definitions for the C-LOOK disk scheduler
// Field widths, table sizing, opcodes, states and the slot preference rule.
// ----------------------------------------------------------------------------
package csds_pkg;

    localparam int PENDING_DEPTH = 16;
    localparam int TRACK_BITS    = 16;
    localparam int SLOT_BITS     = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    // port field widths
    localparam int ID_W        = 8;
    localparam int TRACK_W     = 16;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;

    // opcodes
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    typedef logic [TRACK_BITS-1:0] track_t;
    typedef logic [ID_W-1:0]       id_t;
    typedef logic [SLOT_BITS-1:0]  slot_t;

    // true when (trk_a, id_a) is preferred over (trk_b, id_b)
    function automatic logic key_less(input track_t trk_a, input id_t id_a,
                                      input track_t trk_b, input id_t id_b);
        return {trk_a, id_a} < {trk_b, id_b};
    endfunction

endpackage

/* sv/circular_scan_disk_scheduler.sv */
// ----------------------------------------------------------------------------
// circular_scan_disk_scheduler: C-LOOK arbiter for a single disk
// Grants the disk at once when idle, queues requests otherwise, and on
// release hands the disk to the next pending track in one-way sweep order.
// ----------------------------------------------------------------------------
//  channel | dir | tuser           | tdata (lowest bit up)
//  s_      | in  | op              | requester_id[7:0], track[23:8]
//  m_      | out | grant_valid     | grant_id[7:0], grant_track[23:8],
//          |     |                 | dropped[24], disk_busy[25], zero[31:26]
//
// A request, or a release with the disk idle, is answered from the idle state.
// A release with the disk busy scans every pending-table slot in turn: one
// compare step per slot against both running bests, then a commit.
// aresetn is synchronous: it empties the pending table and idles the disk.
// A new transaction is taken only in the idle state and while the output
// register is empty or being drained; a stalled result holds the sequencer.
module circular_scan_disk_scheduler
    import csds_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // requester_id, track
    input  logic                 s_tuser,   // op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // grant_id, grant_track, dropped, disk_busy
    output logic                 m_tuser    // grant_valid
);

    logic [1:0]   state_reg, state_next;
    logic         busy_reg, busy_next;
    track_t       cur_track_reg, cur_track_next;

    logic [PENDING_DEPTH-1:0] slot_valid_reg, slot_valid_next;
    track_t       slot_track_mem [PENDING_DEPTH];
    id_t          slot_id_mem    [PENDING_DEPTH];
    track_t       rd_trk_reg;
    id_t          rd_id_reg;

    slot_t        scan_idx_reg, scan_idx_next;
    logic         any_found_reg, any_found_next;
    slot_t        any_slot_reg, any_slot_next;
    track_t       any_trk_reg, any_trk_next;
    id_t          any_id_reg, any_id_next;
    logic         above_found_reg, above_found_next;
    slot_t        above_slot_reg, above_slot_next;
    track_t       above_trk_reg, above_trk_next;
    id_t          above_id_reg, above_id_next;

    logic         m_valid_reg, m_valid_next;
    logic         out_grant_reg, out_grant_next;
    id_t          out_id_reg, out_id_next;
    logic [TRACK_W-1:0] out_trk_reg, out_trk_next;
    logic         out_drop_reg, out_drop_next;
    logic         out_busy_reg, out_busy_next;

    logic         wr_en;
    slot_t        wr_slot;
    logic         free_found;
    slot_t        free_idx;
    logic         in_fire, out_free;
    logic         in_op;
    id_t          in_id;
    track_t       in_trk;
    logic         cur_valid;
    track_t       cur_trk;
    id_t          cur_id;
    logic         take_any, take_above;
    slot_t        grant_slot;
    track_t       grant_trk;
    id_t          grant_id;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;
    assign in_op    = s_tuser;
    assign in_id    = s_tdata[ID_W-1:0];
    assign in_trk   = TRACK_BITS'(s_tdata[ID_W +: TRACK_W]);

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
            if (!slot_valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_BITS'(i);
            end
        end
    end

    // one scan step: compare the slot under the index against both bests
    assign cur_valid  = slot_valid_reg[scan_idx_reg];
    assign cur_trk    = rd_trk_reg;
    assign cur_id     = rd_id_reg;
    assign take_any   = cur_valid &&
                        (!any_found_reg || key_less(cur_trk, cur_id, any_trk_reg, any_id_reg));
    assign take_above = cur_valid && (cur_trk >= cur_track_reg) &&
                        (!above_found_reg ||
                         key_less(cur_trk, cur_id, above_trk_reg, above_id_reg));

    assign grant_slot = above_found_reg ? above_slot_reg : any_slot_reg;
    assign grant_trk  = above_found_reg ? above_trk_reg  : any_trk_reg;
    assign grant_id   = above_found_reg ? above_id_reg   : any_id_reg;

    always_comb begin
        state_next       = state_reg;
        busy_next        = busy_reg;
        cur_track_next   = cur_track_reg;
        slot_valid_next  = slot_valid_reg;
        scan_idx_next    = scan_idx_reg;
        any_found_next   = any_found_reg;
        any_slot_next    = any_slot_reg;
        any_trk_next     = any_trk_reg;
        any_id_next      = any_id_reg;
        above_found_next = above_found_reg;
        above_slot_next  = above_slot_reg;
        above_trk_next   = above_trk_reg;
        above_id_next    = above_id_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        out_grant_next   = out_grant_reg;
        out_id_next      = out_id_reg;
        out_trk_next     = out_trk_reg;
        out_drop_next    = out_drop_reg;
        out_busy_next    = out_busy_reg;
        wr_en            = 1'b0;
        wr_slot          = free_idx;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    out_grant_next = 1'b0;
                    out_id_next    = '0;
                    out_trk_next   = '0;
                    out_drop_next  = 1'b0;
                    out_busy_next  = busy_reg;
                    if (in_op == OP_REQUEST) begin
                        m_valid_next = 1'b1;
                        if (!busy_reg) begin
                            busy_next      = 1'b1;
                            cur_track_next = in_trk;
                            out_grant_next = 1'b1;
                            out_id_next    = in_id;
                            out_trk_next   = TRACK_W'(in_trk);
                            out_busy_next  = 1'b1;
                        end else if (free_found) begin
                            wr_en                     = 1'b1;
                            slot_valid_next[free_idx] = 1'b1;
                        end else begin
                            out_drop_next = 1'b1;
                        end
                    end else if (!busy_reg) begin
                        // release with nothing owned: report idle
                        m_valid_next = 1'b1;
                    end else begin
                        scan_idx_next    = '0;
                        any_found_next   = 1'b0;
                        above_found_next = 1'b0;
                        state_next       = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (take_any) begin
                    any_found_next = 1'b1;
                    any_slot_next  = scan_idx_reg;
                    any_trk_next   = cur_trk;
                    any_id_next    = cur_id;
                end
                if (take_above) begin
                    above_found_next = 1'b1;
                    above_slot_next  = scan_idx_reg;
                    above_trk_next   = cur_trk;
                    above_id_next    = cur_id;
                end
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == SLOT_BITS'(PENDING_DEPTH - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the pick until the output register can take it
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_drop_next = 1'b0;
                    if (any_found_reg) begin
                        slot_valid_next[grant_slot] = 1'b0;
                        cur_track_next = grant_trk;
                        out_grant_next = 1'b1;
                        out_id_next    = grant_id;
                        out_trk_next   = TRACK_W'(grant_trk);
                        out_busy_next  = 1'b1;
                    end else begin
                        busy_next      = 1'b0;
                        out_grant_next = 1'b0;
                        out_id_next    = '0;
                        out_trk_next   = '0;
                        out_busy_next  = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            busy_reg        <= 1'b0;
            cur_track_reg   <= '0;
            slot_valid_reg  <= '0;
            scan_idx_reg    <= '0;
            any_found_reg   <= 1'b0;
            above_found_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            busy_reg        <= busy_next;
            cur_track_reg   <= cur_track_next;
            slot_valid_reg  <= slot_valid_next;
            scan_idx_reg    <= scan_idx_next;
            any_found_reg   <= any_found_next;
            above_found_reg <= above_found_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        any_slot_reg   <= any_slot_next;
        any_trk_reg    <= any_trk_next;
        any_id_reg     <= any_id_next;
        above_slot_reg <= above_slot_next;
        above_trk_reg  <= above_trk_next;
        above_id_reg   <= above_id_next;
        out_grant_reg  <= out_grant_next;
        out_id_reg     <= out_id_next;
        out_trk_reg    <= out_trk_next;
        out_drop_reg   <= out_drop_next;
        out_busy_reg   <= out_busy_next;
    end

    // pending table storage; read one slot ahead so the data lines up with the scan index
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_track_mem[wr_slot] <= in_trk;
            slot_id_mem[wr_slot]    <= in_id;
        end
        rd_trk_reg <= slot_track_mem[scan_idx_next];
        rd_id_reg  <= slot_id_mem[scan_idx_next];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_grant_reg;
    assign m_tdata  = {{(M_TDATA_W - ID_W - TRACK_W - 2){1'b0}},
                       out_busy_reg, out_drop_reg, out_trk_reg, out_id_reg};

`ifndef SYNTHESIS
    // a request that finds the disk idle is granted on the next result
    a_idle_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_op == OP_REQUEST && !busy_reg)
        |=> (m_valid_reg && out_grant_reg && busy_reg))
        else $error("idle request not granted");

    // nothing may be pending while the disk is idle
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (slot_valid_reg == '0))
        else $error("pending slot while disk idle");

    // a drop is reported only with a full table
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_drop_reg) |-> (&slot_valid_reg))
        else $error("request dropped with free slot");

    // no new transaction while a scan is running
    a_scan_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_DONE) |-> !s_tready)
        else $error("input accepted during scan");
`endif

endmodule

/* verif/csds_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csds_checker: scoreboard for the C-LOOK disk scheduler
// Watches both stream channels. Each accepted input transaction runs through
// a local copy of the pending table and sweep position to predict its grant
// result. Each output transaction is then compared field by field against the
// oldest prediction.
// ----------------------------------------------------------------------------
module csds_checker
    import csds_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // requester_id, track
    input  logic                 s_tuser,   // op
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // grant_id, grant_track, dropped, disk_busy
    input  logic                 m_tuser,   // grant_valid
    output int                   error_count,
    output int                   outstanding,
    output int                   results_seen,
    output int                   grants_made,
    output int                   wraps_made,
    output int                   drops_made,
    output int                   idle_releases
);

    typedef struct {
        logic   grant_valid;
        id_t    grant_id;
        track_t grant_track;
        logic   dropped;
        logic   disk_busy;
    } grant_t;

    grant_t expected_grants[$];

    // shadow of the scheduler state
    logic   disk_owned;
    track_t head_track;
    logic   slot_busy  [PENDING_DEPTH];
    track_t slot_trk   [PENDING_DEPTH];
    id_t    slot_owner [PENDING_DEPTH];

    int errs, n_results, n_grants, n_wraps, n_drops, n_idle;

    assign error_count   = errs;
    assign results_seen  = n_results;
    assign grants_made   = n_grants;
    assign wraps_made    = n_wraps;
    assign drops_made    = n_drops;
    assign idle_releases = n_idle;

    task automatic report_mismatch(input string msg);
        errs++;
        if (errs <= 40)
            $display("[%0t] MISMATCH result %0d: %s", $time, n_results, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // slot a wins over slot b: smaller track first, then smaller id
    function automatic bit prefer(input int a, input int b);
        if (slot_trk[a] != slot_trk[b])
            return slot_trk[a] < slot_trk[b];
        return slot_owner[a] < slot_owner[b];
    endfunction

    function automatic grant_t schedule_next(input logic op, input id_t id,
                                             input track_t trk);
        grant_t g;
        int     free_idx;
        int     above_idx;
        int     lowest_idx;
        g = '{grant_valid: 1'b0, grant_id: '0, grant_track: '0,
              dropped: 1'b0, disk_busy: 1'b0};
        free_idx   = -1;
        above_idx  = -1;
        lowest_idx = -1;
        if (op == OP_REQUEST) begin
            if (!disk_owned) begin
                disk_owned    = 1'b1;
                head_track    = trk;
                g.grant_valid = 1'b1;
                g.grant_id    = id;
                g.grant_track = trk;
            end else begin
                for (int i = 0; i < PENDING_DEPTH; i++)
                    if (!slot_busy[i] && free_idx < 0)
                        free_idx = i;
                if (free_idx < 0) begin
                    g.dropped = 1'b1;
                    n_drops++;
                end else begin
                    slot_busy[free_idx]  = 1'b1;
                    slot_trk[free_idx]   = trk;
                    slot_owner[free_idx] = id;
                end
            end
        end else if (!disk_owned) begin
            n_idle++;
        end else begin
            for (int i = 0; i < PENDING_DEPTH; i++) begin
                if (slot_busy[i]) begin
                    if (lowest_idx < 0 || prefer(i, lowest_idx))
                        lowest_idx = i;
                    if (slot_trk[i] >= head_track && (above_idx < 0 || prefer(i, above_idx)))
                        above_idx = i;
                end
            end
            if (lowest_idx < 0) begin
                disk_owned = 1'b0;
            end else begin
                // nothing left ahead of the head: wrap to the lowest track
                if (above_idx < 0) begin
                    above_idx = lowest_idx;
                    n_wraps++;
                end
                slot_busy[above_idx] = 1'b0;
                head_track    = slot_trk[above_idx];
                g.grant_valid = 1'b1;
                g.grant_id    = slot_owner[above_idx];
                g.grant_track = slot_trk[above_idx];
            end
        end
        if (g.grant_valid)
            n_grants++;
        g.disk_busy = disk_owned;
        return g;
    endfunction

    always @(posedge aclk) begin
        grant_t want;
        if (!aresetn) begin
            disk_owned = 1'b0;
            head_track = '0;
            for (int i = 0; i < PENDING_DEPTH; i++) begin
                slot_busy[i]  = 1'b0;
                slot_trk[i]   = '0;
                slot_owner[i] = '0;
            end
            expected_grants.delete();
            errs      = 0;
            n_results = 0;
            n_grants  = 0;
            n_wraps   = 0;
            n_drops   = 0;
            n_idle    = 0;
            outstanding <= 0;
        end else begin
            // compare the output side first: a result can never belong to
            // an input taken at the same edge
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_grants.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction tdata 0x%0h", m_tdata));
                end else begin
                    want = expected_grants.pop_front();
                    check_field("grant_valid", m_tuser, want.grant_valid);
                    check_field("grant_id", m_tdata[7:0], want.grant_id);
                    check_field("grant_track", m_tdata[23:8], want.grant_track);
                    check_field("dropped", m_tdata[24], want.dropped);
                    check_field("disk_busy", m_tdata[25], want.disk_busy);
                    check_field("pad bits", m_tdata[31:26], 0);
                end
            end
            if (s_tvalid && s_tready)
                expected_grants.push_back(schedule_next(s_tuser, s_tdata[7:0], s_tdata[23:8]));
            outstanding <= expected_grants.size();
        end
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the C-LOOK disk scheduler
// Drives a directed sequence (idle release, immediate grant, a full pending
// table with ties and an overflow, sweep and wrap-around releases), then
// blocks of random requests and releases with varying request density.
// Both channels idle at random; the sink holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import csds_pkg::*;

    localparam int RAND_BLOCKS  = 35;
    localparam int BLOCK_ITEMS  = 50;
    localparam int HOLD_START   = 2500;
    localparam int HOLD_LEN     = 400;
    localparam int STEADY_START = 9000;
    localparam int STEADY_END   = 12000;
    localparam int DRAIN_LIMIT  = 200000;

    // pending-table fill: five tracks at or above the first grant, the rest below
    localparam id_t SEED_IDS [PENDING_DEPTH] = '{
        8'd3,    8'd1,    8'd1,    8'hAA,   8'hFF,   8'd0,    8'h55,   8'd7,
        8'd9,    8'hFF,   8'h10,   8'h22,   8'h33,   8'h44,   8'h66,   8'h77};
    localparam track_t SEED_TRACKS [PENDING_DEPTH] = '{
        16'h8000, 16'h8000, 16'h8000, 16'hAAAA, 16'hFFFF, 16'h0000, 16'h5555, 16'h7FFF,
        16'h0001, 16'h0000, 16'h0FFF, 16'h1234, 16'h4000, 16'h0100, 16'h7FFE, 16'h2000};

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // requester_id, track
    logic                 s_tuser  = 1'b0; // op
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // grant_id, grant_track, dropped, disk_busy
    logic                 m_tuser;         // grant_valid

    int error_count, outstanding, results_seen;
    int grants_made, wraps_made, drops_made, idle_releases;
    bit steady_sender = 1'b0;
    bit drain_timeout = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    circular_scan_disk_scheduler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    csds_checker scoreboard (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_count   (error_count),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .grants_made   (grants_made),
        .wraps_made    (wraps_made),
        .drops_made    (drops_made),
        .idle_releases (idle_releases)
    );

    task automatic send_item(input logic op, input id_t id, input track_t trk);
        while (!steady_sender && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {trk, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // drop valid and wait for every predicted result to come out
    task automatic drain_results();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0 && !drain_timeout) begin
            @(posedge aclk);
            waited++;
            if (waited > DRAIN_LIMIT)
                drain_timeout = 1'b1;
        end
    endtask

    // sink side: random backpressure, one long hold-off, one steady stretch
    initial begin : sink_side
        int cyc;
        cyc = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
                m_tready <= 1'b0;
            else if (cyc >= STEADY_START && cyc < STEADY_END)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 35);
        end
    end

    initial begin : source_side
        int     req_pct;
        logic   op;
        id_t    id;
        track_t trk;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle release, then an immediate grant in mid-disk
        send_item(OP_RELEASE, 8'h00, 16'h0000);
        send_item(OP_REQUEST, 8'h80, 16'h8000);
        // fill every slot, then overflow
        for (int i = 0; i < PENDING_DEPTH; i++)
            send_item(OP_REQUEST, SEED_IDS[i], SEED_TRACKS[i]);
        send_item(OP_REQUEST, 8'h99, 16'h9999);
        // sweep up through the ties, the top track, then wrap
        for (int i = 0; i < 6; i++)
            send_item(OP_RELEASE, 8'hFF, 16'hFFFF);

        for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
            case ($urandom_range(3))
                0:       req_pct = 25;
                1:       req_pct = 50;
                2:       req_pct = 65;
                default: req_pct = 90;
            endcase
            steady_sender = (blk >= 12 && blk < 17);
            if (blk == 22)
                drain_results();
            for (int k = 0; k < BLOCK_ITEMS; k++) begin
                op = ($urandom_range(99) < req_pct) ? OP_REQUEST : OP_RELEASE;
                // small ids make equal-track ties more likely to need the id rule
                id = ($urandom_range(3) == 0) ? id_t'($urandom_range(3))
                                              : id_t'($urandom_range(255));
                case ($urandom_range(7))
                    0:       trk = track_t'($urandom_range(7));
                    1:       trk = 16'hFFFF - track_t'($urandom_range(7));
                    2, 3:    trk = {4'($urandom_range(15)), 12'h800};
                    default: trk = track_t'($urandom);
                endcase
                send_item(op, id, trk);
            end
        end
        steady_sender = 1'b0;

        drain_results();
        repeat (PENDING_DEPTH + 8) @(posedge aclk);

        $display("Checked %0d transactions: %0d grants (%0d wrap-around), %0d drops,",
                 results_seen, grants_made, wraps_made, drops_made);
        $display("%0d releases on an idle disk, %0d mismatches.", idle_releases, error_count);
        if (error_count == 0 && outstanding == 0 && !drain_timeout) begin
            $display("circular_scan_disk_scheduler test passed");
        end else begin
            $display("circular_scan_disk_scheduler test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("circular_scan_disk_scheduler test failed");
        $finish;
    end

endmodule

/* files.f */
sv/csds_pkg.sv
sv/circular_scan_disk_scheduler.sv
verif/csds_checker.sv
verif/tb_top.sv
